// ===== src/nsr_pkg.sv =====
// Shared constants and pipeline stage type for the square root core.
`timescale 1ns / 1ps
package nsr_pkg;
   localparam int VALUE_W     = 32;
   localparam int ROOT_W      = 24;
   localparam int MANT_FRAC   = 30;
   localparam int MANT_W      = 32;
   localparam int SHIFT_W     = 5;
   localparam int STEP_STAGES = MANT_W + 1;
   localparam int FRONT_STAGES = 3;
   localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic [SHIFT_W-1:0] sh;
      logic [MANT_W-1:0]  mant;
      logic [MANT_W-1:0]  x;
      logic [MANT_W-1:0]  rem;
      logic [MANT_W-1:0]  quo;
   } stage_type;
endpackage

// ===== src/newton_square_root_core.sv =====
// Pipelined Newton-Raphson square root, unsigned fixed point in and out.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+--------------------------------
//  request | start, busy, req_value         | taken when start && !busy
//  result  | rsp_valid, rsp_root            | one-cycle strobe, no back-pressure
//
// One item per cycle. Each Newton step is a 32-stage restoring divider, one quotient
// bit per stage, plus one averaging stage. busy stays low; the pipe never stalls.
// Synchronous reset clears the valid bits only.
`timescale 1ns / 1ps
module newton_square_root_core
   import nsr_pkg::*;
#(
   parameter int NEWTON_STEPS = 5,
   parameter int FRAC_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   output logic [ROOT_W-1:0]  rsp_root
);
   localparam int TOTAL = NEWTON_STEPS * STEP_STAGES;

   logic               s1_valid_ff, s1_zero_ff;
   logic [4:0]         s1_pos_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [4:0]         s1_pos_in;

   logic               s2_valid_ff, s2_zero_ff;
   logic [SHIFT_W-1:0] s2_sh_ff, s2_sh_in;
   logic [MANT_W-1:0]  s2_mant_ff, s2_mant_in;

   stage_type pipe_ff [0:TOTAL];
   stage_type pipe_in [0:TOTAL];

   logic               rsp_valid_ff;
   logic [ROOT_W-1:0]  rsp_root_ff, rsp_root_in;

   assign busy = 1'b0;

   always_comb begin
      s1_pos_in = '0;
      for (int i = 1; i < VALUE_W; i++) begin
         if (req_value[i]) s1_pos_in = 5'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_zero_ff  <= (req_value == '0);
      s1_pos_ff   <= s1_pos_in;
      s1_value_ff <= req_value;
   end

   always_comb begin
      int t;
      int s;
      t = MANT_FRAC - int'(s1_pos_ff);
      if (((t - FRAC_BITS) & 1) != 0) t = t + 1;
      s = (MANT_FRAC + t - FRAC_BITS) >>> 1;
      s2_sh_in = s[SHIFT_W-1:0];
      if (s1_zero_ff) begin
         s2_mant_in = MANT_W'(1) << MANT_FRAC;
      end else if (t < 0) begin
         s2_mant_in = s1_value_ff >> 1;
      end else begin
         s2_mant_in = s1_value_ff << t[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_zero_ff <= s1_zero_ff;
      s2_sh_ff   <= s2_sh_in;
      s2_mant_ff <= s2_mant_in;
   end

   always_comb begin
      logic [MANT_W:0] sum;
      sum = {1'b0, s2_mant_ff} + ((MANT_W+1)'(1) << MANT_FRAC);
      pipe_in[0]       = '0;
      pipe_in[0].valid = s2_valid_ff;
      pipe_in[0].zero  = s2_zero_ff;
      pipe_in[0].sh    = s2_sh_ff;
      pipe_in[0].mant  = s2_mant_ff;
      pipe_in[0].x     = sum[MANT_W:1];
   end

   for (genvar k = 0; k < TOTAL; k++) begin : g_stage
      localparam int J = k % STEP_STAGES;
      always_comb begin
         logic [MANT_W-1:0] rem_src;
         logic              bit_in;
         logic [MANT_W:0]   trial;
         logic [MANT_W:0]   sum;
         logic              ge;
         pipe_in[k+1] = pipe_ff[k];
         rem_src = (J == 0) ? {2'b00, pipe_ff[k].mant[MANT_W-1:2]} : pipe_ff[k].rem;
         bit_in  = (J == 0) ? pipe_ff[k].mant[1] :
                   (J == 1) ? pipe_ff[k].mant[0] : 1'b0;
         trial = {rem_src, bit_in};
         ge    = (trial >= {1'b0, pipe_ff[k].x});
         sum   = {1'b0, pipe_ff[k].x} + {1'b0, pipe_ff[k].quo};
         if (J < MANT_W) begin
            pipe_in[k+1].rem = ge ? MANT_W'(trial - {1'b0, pipe_ff[k].x}) : trial[MANT_W-1:0];
            pipe_in[k+1].quo = {pipe_ff[k].quo[MANT_W-2:0], ge};
         end else begin
            pipe_in[k+1].x = sum[MANT_W:1];
         end
      end
   end

   for (genvar k = 0; k <= TOTAL; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[k].valid <= 1'b0;
         end else begin
            pipe_ff[k].valid <= pipe_in[k].valid;
         end
         pipe_ff[k].zero <= pipe_in[k].zero;
         pipe_ff[k].sh   <= pipe_in[k].sh;
         pipe_ff[k].mant <= pipe_in[k].mant;
         pipe_ff[k].x    <= pipe_in[k].x;
         pipe_ff[k].rem  <= pipe_in[k].rem;
         pipe_ff[k].quo  <= pipe_in[k].quo;
      end
   end

   always_comb begin
      logic [MANT_W-1:0] shifted;
      shifted = pipe_ff[TOTAL].x >> pipe_ff[TOTAL].sh;
      if (pipe_ff[TOTAL].zero) begin
         rsp_root_in = '0;
      end else if (shifted > MANT_W'(ROOT_MAX)) begin
         rsp_root_in = ROOT_MAX;
      end else begin
         rsp_root_in = shifted[ROOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_ff[TOTAL].valid;
      end
      rsp_root_ff <= rsp_root_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = rsp_root_ff;
endmodule

// ===== src/nsr_checker.sv =====
// Port-level checks for the square root core, bound to the top level.
`timescale 1ns / 1ps
module nsr_checker
   import nsr_pkg::*;
#(
   parameter int NEWTON_STEPS = 5
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [VALUE_W-1:0] req_value,
   input logic               rsp_valid,
   input logic [ROOT_W-1:0]  rsp_root
);
   localparam int LAT = FRONT_STAGES + NEWTON_STEPS * STEP_STAGES + 1;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching item");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, LAT) && $past(!reset, LAT) && $past(!reset, 1))
      |-> rsp_valid)
      else $error("item lost");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_value == '0, LAT)) |-> (rsp_root == '0))
      else $error("zero radicand gave non-zero root");

   a_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result straight after reset");
endmodule

bind newton_square_root_core nsr_checker #(.NEWTON_STEPS(NEWTON_STEPS)) u_nsr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_value (req_value),
   .rsp_valid (rsp_valid),
   .rsp_root  (rsp_root)
);
